[design/infusion_rate_and_alarm_step_assert.svh]
// assertion macros for the infusion rate and alarm step block
// used by the top level only; expects clk and rst in scope
`ifndef INFUSION_RATE_AND_ALARM_STEP_ASSERT_SVH
`define INFUSION_RATE_AND_ALARM_STEP_ASSERT_SVH
`ifndef SYNTHESIS
`define IRAS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("iras assertion failed");
`define IRAS_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("iras forbidden condition");
`else
`define IRAS_ASSERT(lbl, prop)
`define IRAS_ASSERT_NEVER(lbl, cond)
`endif
`endif

[design/iras_pkg.sv]
// shared types and constants for the infusion rate and alarm step block
// no dependencies
`default_nettype none

package iras_pkg;

  localparam int RATE_W   = 24;
  localparam int DELAY_W  = 32;
  localparam int VOL_W    = 76;
  localparam int PROD_W   = 56;
  localparam int NUM_W    = 33;
  localparam int HALF_W   = 28;
  localparam int PART_W   = 43;

  localparam logic [NUM_W-1:0]   DELAY_NUM = 33'd4608000000;
  localparam logic [DELAY_W-1:0] DELAY_MAX = 32'hFFFF_FFFF;
  localparam logic [14:0]        VOL_SCALE = 15'd28125;

  localparam logic [RATE_W-1:0] VPP_RESET    = 24'd83886;
  localparam logic [15:0]       PLIMIT_RESET = 16'd300;

  typedef enum logic [2:0] {
    REG_MODE,
    REG_CONST_RATE,
    REG_RAMP_START,
    REG_RAMP_STEP,
    REG_RAMP_FINAL,
    REG_TRACKER_RATE,
    REG_VOL_PER_PULSE,
    REG_PRESSURE_LIMIT
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_EXP,
    S_MUL_ACT,
    S_MUL_LO,
    S_MUL_HI,
    S_ACCUM,
    S_DIFF,
    S_SCALE,
    S_CMP,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [31:0] elapsed_ms;
    logic [31:0] pulse_count;
    logic [15:0] pressure;
  } item_t;

  typedef struct packed {
    logic [RATE_W-1:0]  target_rate;
    logic [DELAY_W-1:0] step_delay_us;
    logic               volume_alarm;
    logic               occlusion_alarm;
  } result_t;

  typedef struct packed {
    logic               busy;
    logic [DELAY_W-1:0] quot;
  } div_stat_t;

endpackage

`default_nettype wire

[design/infusion_rate_and_alarm_step.sv]
// Infusion rate and alarm step, top level.
// One input word is one control tick (elapsed_ms, pulse_count, pressure);
// each tick gives exactly one result word (target_rate, step_delay_us,
// volume_alarm, occlusion_alarm). Both channels use valid/stall; a word moves
// at a clock edge with valid high and stall low.
// The target rate comes from constant_rate or from the ramp level, which is
// loaded from ramp_start on the first ramp tick after reset.
// The result is loaded once both the 33-step restoring divider for
// step_delay_us and the multiply/compare sequence on the shared 32x24
// multiplier are done; with a zero rate the divider does not run, so the
// sequence alone sets when the result is loaded.
// One tick is in work at a time; item_stall is high from accept until the
// result is loaded, so a new tick is taken only after the last one is through.
// The result sits in an output register; a new tick may be accepted while it
// waits, and a finished tick holds until result_stall drops.
// Synchronous reset clears the ramp state, restores the register defaults and
// drops result_valid. Registers are written through cfg_we/cfg_index/cfg_data
// only while the block is idle: a rule for the user, not enforced by the block.
// depends on iras_pkg, iras_mul, iras_div and the assertion macro header
`default_nettype none
`include "infusion_rate_and_alarm_step_assert.svh"

module infusion_rate_and_alarm_step
  import iras_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [RATE_W-1:0] cfg_data,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire item_t             item,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output result_t                result
);

  // configuration registers
  logic              mode;
  logic [RATE_W-1:0] constant_rate;
  logic [RATE_W-1:0] ramp_start;
  logic [RATE_W-1:0] ramp_step;
  logic [RATE_W-1:0] ramp_final;
  logic [RATE_W-1:0] tracker_rate;
  logic [RATE_W-1:0] volume_per_pulse;
  logic [15:0]       pressure_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= 1'b0;
      constant_rate    <= '0;
      ramp_start       <= '0;
      ramp_step        <= '0;
      ramp_final       <= '0;
      tracker_rate     <= '0;
      volume_per_pulse <= VPP_RESET;
      pressure_limit   <= PLIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE:           mode             <= cfg_data[0];
        REG_CONST_RATE:     constant_rate    <= cfg_data;
        REG_RAMP_START:     ramp_start       <= cfg_data;
        REG_RAMP_STEP:      ramp_step        <= cfg_data;
        REG_RAMP_FINAL:     ramp_final       <= cfg_data;
        REG_TRACKER_RATE:   tracker_rate     <= cfg_data;
        REG_VOL_PER_PULSE:  volume_per_pulse <= cfg_data;
        REG_PRESSURE_LIMIT: pressure_limit   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  logic   accept;
  logic   load_result;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;

  // ramp level: add signed step, cap at final, floor at zero
  logic              ramp_loaded;
  logic [RATE_W-1:0] ramp_level;
  logic [RATE_W-1:0] ramp_base;
  logic signed [RATE_W+1:0] ramp_sum;
  logic [RATE_W-1:0] ramp_level_next;
  logic [RATE_W-1:0] rate_sel;

  assign ramp_base = ramp_loaded ? ramp_level : ramp_start;
  assign ramp_sum  = $signed({2'b00, ramp_base})
                   + $signed({{2{ramp_step[RATE_W-1]}}, ramp_step});

  always_comb begin
    if (ramp_sum > $signed({2'b00, ramp_final})) begin
      ramp_level_next = ramp_final;
    end else if (ramp_sum < 0) begin
      ramp_level_next = '0;
    end else begin
      ramp_level_next = ramp_sum[RATE_W-1:0];
    end
  end

  assign rate_sel = mode ? ramp_level_next : constant_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_loaded <= 1'b0;
      ramp_level  <= '0;
    end else if (accept && mode) begin
      ramp_loaded <= 1'b1;
      ramp_level  <= ramp_level_next;
    end
  end

  // shared units
  logic [31:0]       mul_a;
  logic [RATE_W-1:0] mul_b;
  logic [PROD_W-1:0] mul_p;
  div_stat_t         div_st;

  iras_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  iras_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .divisor (rate_sel),
    .stat    (div_st)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic [HALF_W-1:0] act_hi;
  logic [31:0]       elapsed_q;
  logic [31:0]       pulses_q;

  always_comb begin
    state_next  = state;
    mul_a       = '0;
    mul_b       = '0;
    load_result = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_MUL_EXP;
        end
      end
      S_MUL_EXP: begin
        mul_a      = elapsed_q;
        mul_b      = tracker_rate;
        state_next = S_MUL_ACT;
      end
      S_MUL_ACT: begin
        mul_a      = pulses_q;
        mul_b      = volume_per_pulse;
        state_next = S_MUL_LO;
      end
      S_MUL_LO: begin
        mul_a      = {4'b0, mul_p[HALF_W-1:0]};
        mul_b      = {9'b0, VOL_SCALE};
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        mul_a      = {4'b0, act_hi};
        mul_b      = {9'b0, VOL_SCALE};
        state_next = S_ACCUM;
      end
      S_ACCUM:  state_next = S_DIFF;
      S_DIFF:   state_next = S_SCALE;
      S_SCALE:  state_next = S_CMP;
      S_CMP:    state_next = S_FINISH;
      S_FINISH: begin
        if (!div_st.busy && (!result_valid || !result_stall)) begin
          load_result = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath registers
  logic [RATE_W-1:0] rate_q;
  logic              occl_q;
  logic [VOL_W-1:0]  exp_q;
  logic [VOL_W-1:0]  vol_q;
  logic [PART_W-1:0] acc_lo;
  logic              alarm_q;
  logic              exp_ge;

  assign exp_ge = exp_q >= vol_q;

  always_ff @(posedge clk) begin
    if (accept) begin
      elapsed_q <= item.elapsed_ms;
      pulses_q  <= item.pulse_count;
      rate_q    <= rate_sel;
      occl_q    <= item.pressure > pressure_limit;
    end
    case (state)
      S_MUL_ACT: exp_q  <= VOL_W'(mul_p) << 9;
      S_MUL_LO:  act_hi <= mul_p[PROD_W-1:HALF_W];
      S_MUL_HI:  acc_lo <= mul_p[PART_W-1:0];
      S_ACCUM:   vol_q  <= (VOL_W'(mul_p[PART_W-1:0]) << HALF_W) + VOL_W'(acc_lo);
      S_DIFF:    vol_q  <= exp_ge ? (exp_q - vol_q) : (vol_q - exp_q);
      S_SCALE:   vol_q  <= (vol_q << 4) + (vol_q << 2);
      S_CMP:     alarm_q <= vol_q > exp_q;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result.target_rate     <= rate_q;
      result.step_delay_us   <= div_st.quot;
      result.volume_alarm    <= alarm_q;
      result.occlusion_alarm <= occl_q;
    end
  end

  `IRAS_ASSERT(a_result_from_finish, $rose(result_valid) |-> $past(state) == S_FINISH)
  `IRAS_ASSERT(a_busy_after_accept, accept |=> item_stall)
  `IRAS_ASSERT(a_ramp_sticky, ramp_loaded |=> ramp_loaded)
  `IRAS_ASSERT_NEVER(a_zero_rate_delay,
    result_valid && result.target_rate == '0 && result.step_delay_us != DELAY_MAX)

endmodule

`default_nettype wire

[design/iras_mul.sv]
// shared 32x24 multiplier with registered product
// depends on iras_pkg
`default_nettype none

module iras_mul
  import iras_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [31:0]       a,
  input  wire logic [RATE_W-1:0] b,
  output logic      [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

`default_nettype wire

[design/iras_div.sv]
// restoring divider, one quotient bit per cycle, of the fixed delay numerator by the rate
// depends on iras_pkg
`default_nettype none

module iras_div
  import iras_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [RATE_W-1:0] divisor,
  output div_stat_t              stat
);

  localparam logic [5:0] CNT_TOP = 6'(NUM_W - 1);

  logic              busy;
  logic [5:0]        cnt;
  logic [RATE_W-1:0] rem;
  logic [RATE_W-1:0] dvs;
  logic [NUM_W-1:0]  quo;
  logic              zero;
  logic [RATE_W:0]   trial;
  logic [RATE_W:0]   trial_sub;
  logic              fits;

  assign trial     = {rem, DELAY_NUM[cnt]};
  assign trial_sub = trial - {1'b0, dvs};
  assign fits      = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= (divisor != '0);
      cnt  <= CNT_TOP;
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end
      cnt <= cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= '0;
      dvs  <= divisor;
      zero <= (divisor == '0);
    end else if (busy) begin
      rem <= fits ? trial_sub[RATE_W-1:0] : trial[RATE_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  // quotient above 32 bits or zero rate saturates
  assign stat.busy = busy;
  assign stat.quot = (zero || quo[NUM_W-1]) ? DELAY_MAX : quo[DELAY_W-1:0];

endmodule

`default_nettype wire

[tb/tb_top.sv]
// self-checking testbench for infusion_rate_and_alarm_step: random valid/stall traffic
// with an in-bench model of the rate, ramp, step delay and alarm logic
// depends on iras_pkg and the infusion_rate_and_alarm_step top level
`timescale 1ns / 100ps

module tb_top;
  import iras_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SEGMENTS = 21;
  localparam int TICKS_PER_SEGMENT = 50;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [RATE_W-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;

  // register image and ramp state as the block should hold them
  logic cfg_mode;
  logic [23:0] cfg_const_rate;
  logic [23:0] cfg_ramp_start;
  logic signed [23:0] cfg_ramp_step;
  logic [23:0] cfg_ramp_final;
  logic [23:0] cfg_tracker_rate;
  logic [23:0] cfg_vol_per_pulse;
  logic [15:0] cfg_pressure_limit;
  logic [23:0] ramp_level;
  logic ramp_loaded;

  item_t pending_ticks[$];
  result_t expected_results[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int ticks_checked = 0;
  int settings_used = 0;
  int ramp_ticks = 0;
  int volume_alarms = 0;
  int occlusion_alarms = 0;
  int cycle_count = 0;

  infusion_rate_and_alarm_step dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("infusion_rate_and_alarm_step test failed");
      $finish;
    end
  end

  function automatic result_t compute_tick_result(input item_t t);
    result_t r;
    int stp;
    int lvl;
    logic [23:0] rate;
    logic [63:0] quo;
    logic [79:0] vol_expected;
    logic [79:0] vol_actual;
    logic [79:0] vol_dev;
    if (cfg_mode) begin
      if (!ramp_loaded) begin
        ramp_level = cfg_ramp_start;
        ramp_loaded = 1'b1;
      end
      stp = int'(cfg_ramp_step);
      lvl = int'({8'h00, ramp_level}) + stp;
      if (lvl > int'({8'h00, cfg_ramp_final})) lvl = int'({8'h00, cfg_ramp_final});
      if (lvl < 0) lvl = 0;
      ramp_level = lvl[23:0];
      rate = ramp_level;
      ramp_ticks++;
    end else begin
      rate = cfg_const_rate;
    end
    if (rate == 0) begin
      r.step_delay_us = DELAY_MAX;
    end else begin
      quo = 64'd4608000000 / 64'(rate);
      r.step_delay_us = (quo > 64'(DELAY_MAX)) ? DELAY_MAX : quo[31:0];
    end
    // both volumes brought to a common scale so the five percent test is exact
    vol_expected = (80'(t.elapsed_ms) * 80'(cfg_tracker_rate)) << 9;
    vol_actual = 80'(t.pulse_count) * 80'(cfg_vol_per_pulse) * 80'(28125);
    vol_dev = (vol_expected >= vol_actual) ? vol_expected - vol_actual
                                           : vol_actual - vol_expected;
    r.target_rate = rate;
    r.volume_alarm = (vol_dev * 80'd20) > vol_expected;
    r.occlusion_alarm = t.pressure > cfg_pressure_limit;
    return r;
  endfunction

  // driver: predicts at acceptance, then offers the next word or idles
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) expected_results.push_back(compute_tick_result(item));
      if (!item_valid || !item_stall) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item <= pending_ticks.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted result word against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("result word with no tick outstanding");
          errors++;
        end else begin
          want = expected_results.pop_front();
          ticks_checked++;
          if (want.volume_alarm) volume_alarms++;
          if (want.occlusion_alarm) occlusion_alarms++;
          if (result.target_rate !== want.target_rate) begin
            $error("target_rate: expected %0d, got %0d", want.target_rate, result.target_rate);
            errors++;
          end
          if (result.step_delay_us !== want.step_delay_us) begin
            $error("step_delay_us: expected %0d, got %0d",
                   want.step_delay_us, result.step_delay_us);
            errors++;
          end
          if (result.volume_alarm !== want.volume_alarm) begin
            $error("volume_alarm: expected %0b, got %0b", want.volume_alarm, result.volume_alarm);
            errors++;
          end
          if (result.occlusion_alarm !== want.occlusion_alarm) begin
            $error("occlusion_alarm: expected %0b, got %0b",
                   want.occlusion_alarm, result.occlusion_alarm);
            errors++;
          end
        end
      end
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // issues one register write; the caller lowers cfg_we after a burst
  task automatic write_reg(input cfg_reg_t idx, input logic [23:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_MODE:           cfg_mode = value[0];
      REG_CONST_RATE:     cfg_const_rate = value;
      REG_RAMP_START:     cfg_ramp_start = value;
      REG_RAMP_STEP:      cfg_ramp_step = value;
      REG_RAMP_FINAL:     cfg_ramp_final = value;
      REG_TRACKER_RATE:   cfg_tracker_rate = value;
      REG_VOL_PER_PULSE:  cfg_vol_per_pulse = value;
      REG_PRESSURE_LIMIT: cfg_pressure_limit = value[15:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
    @(negedge clk);
  endtask

  task automatic add_tick(input logic [31:0] e, input logic [31:0] p, input logic [15:0] pr);
    item_t t;
    t.elapsed_ms = e;
    t.pulse_count = p;
    t.pressure = pr;
    pending_ticks.push_back(t);
  endtask

  // block is idle once every tick went in and every result came back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || item_valid || expected_results.size() != 0);
  endtask

  function automatic logic [23:0] pick_rate();
    case ($urandom_range(5))
      0: return 24'd0;
      1: return 24'hFF_FFFF;
      2: return 24'($urandom_range(1, 255));
      3: return 24'($urandom_range(256, 65535));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic program_random_settings();
    logic [23:0] stp;
    case ($urandom_range(3))
      0: stp = 24'($urandom);
      1: stp = $urandom_range(1) ? 24'h80_0000 : 24'h7F_FFFF;
      default: stp = 24'($signed($urandom_range(0, 8192)) - 4096);
    endcase
    // upper data bits beyond a register's width are junk on purpose
    write_reg(REG_MODE, {23'($urandom), 1'($urandom_range(1))});
    write_reg(REG_CONST_RATE, pick_rate());
    write_reg(REG_RAMP_START, pick_rate());
    write_reg(REG_RAMP_STEP, stp);
    write_reg(REG_RAMP_FINAL, $urandom_range(2) == 0 ? 24'hFF_FFFF : pick_rate());
    write_reg(REG_TRACKER_RATE, pick_rate());
    write_reg(REG_VOL_PER_PULSE, $urandom_range(3) == 0 ? VPP_RESET : pick_rate());
    write_reg(REG_PRESSURE_LIMIT,
              {8'($urandom), $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom)});
    end_writes();
  endtask

  task automatic add_random_tick();
    logic [31:0] e;
    logic [31:0] p;
    logic [79:0] num;
    logic [79:0] den;
    logic [79:0] q;
    int pr;
    int kind;
    kind = $urandom_range(9);
    e = $urandom >> $urandom_range(31);
    p = $urandom >> $urandom_range(31);
    if (kind == 9) begin
      e = $urandom;
      p = $urandom;
    end else if (kind < 6 && cfg_vol_per_pulse != 0) begin
      // pulse count within a few percent of the expected volume
      num = 80'(e) * 80'(cfg_tracker_rate) * 80'd512 * 80'($urandom_range(940, 1060));
      den = 80'(cfg_vol_per_pulse) * 80'd28125 * 80'd1000;
      q = num / den;
      p = (q > 80'hFFFF_FFFF) ? $urandom : q[31:0];
    end
    if ($urandom_range(1)) begin
      pr = int'(cfg_pressure_limit) + $urandom_range(4) - 2;
      if (pr < 0) pr = 0;
      if (pr > 65535) pr = 65535;
    end else begin
      pr = $urandom_range(65535);
    end
    add_tick(e, p, 16'(pr));
  endtask

  initial begin
    cfg_mode = 1'b0;
    cfg_const_rate = '0;
    cfg_ramp_start = '0;
    cfg_ramp_step = '0;
    cfg_ramp_final = '0;
    cfg_tracker_rate = '0;
    cfg_vol_per_pulse = VPP_RESET;
    cfg_pressure_limit = PLIMIT_RESET;
    ramp_level = '0;
    ramp_loaded = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 19;
    recv_stall_pct = 83;

    // reset settings: zero rate and zero expected volume
    @(negedge clk);
    add_tick(32'd0, 32'd0, 16'd0);
    add_tick(32'd0, 32'd1, 16'd300);
    add_tick(32'hFFFF_FFFF, 32'd0, 16'd301);
    add_tick(32'd1000, 32'hFFFF_FFFF, 16'hFFFF);
    wait_idle();

    // rate of one lsb overflows the delay; widest volume products
    write_reg(REG_CONST_RATE, 24'd1);
    write_reg(REG_TRACKER_RATE, 24'hFF_FFFF);
    write_reg(REG_VOL_PER_PULSE, 24'hFF_FFFF);
    write_reg(REG_PRESSURE_LIMIT, 24'hAB_0000);
    end_writes();
    add_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
    add_tick(32'hFFFF_FFFF, 32'd0, 16'd1);
    add_tick(32'd0, 32'hFFFF_FFFF, 16'd0);
    wait_idle();

    // 100 ml/h for one hour against pulses near the five percent edge
    write_reg(REG_CONST_RATE, 24'hFF_FFFF);
    write_reg(REG_TRACKER_RATE, 24'd25600);
    write_reg(REG_VOL_PER_PULSE, VPP_RESET);
    write_reg(REG_PRESSURE_LIMIT, 24'h00_FFFF);
    end_writes();
    add_tick(32'd3600000, 32'd19000, 16'hFFFF);
    add_tick(32'd3600000, 32'd21000, 16'd0);
    add_tick(32'd3600000, 32'd20000, 16'd1234);
    wait_idle();

    // ramp loads from its start on the first ramp tick, then caps
    write_reg(REG_MODE, 24'd1);
    write_reg(REG_RAMP_START, 24'd1000);
    write_reg(REG_RAMP_STEP, 24'd300);
    write_reg(REG_RAMP_FINAL, 24'd2000);
    end_writes();
    repeat (4) add_tick($urandom, $urandom, 16'($urandom));
    wait_idle();

    // most negative step floors the level at zero
    write_reg(REG_RAMP_STEP, 24'h80_0000);
    end_writes();
    repeat (2) add_tick($urandom, $urandom, 16'($urandom));
    wait_idle();

    // a late ramp start write must not reload the level
    write_reg(REG_RAMP_START, 24'd5000);
    write_reg(REG_RAMP_STEP, 24'd1);
    end_writes();
    repeat (2) add_tick($urandom, $urandom, 16'($urandom));
    wait_idle();

    // constant mode leaves the ramp alone, which then resumes
    write_reg(REG_MODE, 24'hFF_FFFE);
    end_writes();
    add_tick(32'd5, 32'd5, 16'd5);
    wait_idle();
    write_reg(REG_MODE, 24'd1);
    write_reg(REG_RAMP_STEP, 24'd2);
    end_writes();
    add_tick(32'd7, 32'd7, 16'd7);
    wait_idle();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < SEGMENTS / 3) begin
        send_idle_pct = 19;
        recv_stall_pct = 83;
      end else if (seg < 2 * SEGMENTS / 3) begin
        send_idle_pct = 83;
        recv_stall_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      program_random_settings();
      repeat (TICKS_PER_SEGMENT) add_random_tick();
      wait_idle();
    end

    repeat (60) @(posedge clk);
    $display("checked %0d ticks over %0d register settings, %0d of them ramp ticks",
             ticks_checked, settings_used, ramp_ticks);
    $display("volume alarms expected %0d times, occlusion alarms %0d times",
             volume_alarms, occlusion_alarms);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("infusion_rate_and_alarm_step test passed");
    end else begin
      $display("infusion_rate_and_alarm_step test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/iras_pkg.sv
design/iras_mul.sv
design/iras_div.sv
design/infusion_rate_and_alarm_step.sv
tb/tb_top.sv
